// ===== rtl/iee_pkg.sv =====
// Package: shared constants, types and codes for the infix expression evaluator.
package iee_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH + 1);

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [CNT_W-1:0]       t_count;

    typedef enum logic [2:0] {
        OPC_ADD    = 3'd0,
        OPC_SUB    = 3'd1,
        OPC_MUL    = 3'd2,
        OPC_DIV    = 3'd3,
        OPC_LPAREN = 3'd4
    } t_opc;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DIVZERO   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_MALFORMED = 2'd3
    } t_status;

    // Character classes.
    typedef enum logic [2:0] {
        CC_DIGIT,
        CC_LPAREN,
        CC_RPAREN,
        CC_OPER,
        CC_OTHER
    } t_cclass;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FLUSH,
        S_DISPATCH,
        S_TOPREAD,
        S_TOPCHK,
        S_POP_B,
        S_POP_A,
        S_EXEC,
        S_DIVWAIT,
        S_PUSHOP,
        S_FINAL,
        S_RES_READ,
        S_OUT
    } t_state;

    // Controller -> datapath commands.
    typedef struct packed {
        logic   load_char;
        logic   acc_digit;
        logic   flush;
        logic   read_top_op;
        logic   pop_op;
        logic   pop_b;
        logic   pop_a;
        logic   exec;
        logic   push_cur_op;
        logic   read_result;
        logic   set_err;
        t_status err_code;
        logic   clear;
    } t_cmd;

    // Datapath -> controller status.
    typedef struct packed {
        t_cclass cclass;
        t_opc    cur_op;
        logic    last;
        t_status err;
        t_count  opd_cnt;
        t_count  opr_cnt;
        t_opc    top_op;
        logic    div_busy;
        logic    div_done;
    } t_sts;

    function automatic logic [1:0] prec(input t_opc op);
        logic [1:0] p;
        p = 2'd0;
        if (op == OPC_MUL || op == OPC_DIV) p = 2'd2;
        else if (op == OPC_ADD || op == OPC_SUB) p = 2'd1;
        return p;
    endfunction

endpackage

// ===== rtl/infix_expression_evaluator.sv =====
// Top level: infix expression evaluator with valid/ready character input and result output.
// Takes one ASCII character word per handshake and evaluates the expression with an
// operand stack and an operator stack held in small memories. A digit is accumulated
// into the current number; an operator or ')' first reduces the operator stack as
// precedence or the matching '(' demands, and a division waits for the bit-serial
// divider. The word marked last drains both stacks, then one result word (value,
// status) is offered until taken; the block clears its stacks as the word is taken and
// then accepts the next expression.
// Status: 0 ok, 1 divide by zero, 2 stack overflow, 3 malformed; value is 0 on error.
module infix_expression_evaluator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_character,
    input  logic        i_last_char,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_value,
    output logic [1:0]  o_status
);
    import iee_pkg::*;

    t_cmd    w_cmd;
    t_sts    w_sts;
    t_value  w_result;

    iee_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    iee_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_character (i_character),
        .i_last_char (i_last_char),
        .o_sts       (w_sts),
        .o_result    (w_result)
    );

    // Result word comes straight from the datapath, held until the stacks clear.
    assign o_value  = 32'(signed'(w_result));
    assign o_status = w_sts.err;

    a_handshake_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("input and output both open");
    a_value_zero_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_value == '0) else $error("value nonzero on error");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value)) else $error("result word dropped");
endmodule

// ===== rtl/iee_divider.sv =====
// Iterative restoring divider on magnitudes, one quotient bit per cycle.
module iee_divider (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  iee_pkg::t_value      i_a,
    input  iee_pkg::t_value      i_b,
    output logic                 o_busy,
    output logic                 o_done,
    output iee_pkg::t_value      o_q
);
    import iee_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    t_value               r_quo;
    t_value               r_rem;
    t_value               r_den;
    logic                 r_neg;
    logic                 r_busy;
    logic                 r_done;
    logic [VALUE_WIDTH:0] w_trial;
    t_value               w_sh;

    assign w_sh    = {r_rem[VALUE_WIDTH-2:0], r_quo[VALUE_WIDTH-1]};
    assign w_trial = {r_rem, r_quo[VALUE_WIDTH-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(VALUE_WIDTH);
                r_quo  <= i_a[VALUE_WIDTH-1] ? t_value'(-i_a) : i_a;
                r_den  <= i_b[VALUE_WIDTH-1] ? t_value'(-i_b) : i_b;
                r_rem  <= '0;
                r_neg  <= i_a[VALUE_WIDTH-1] ^ i_b[VALUE_WIDTH-1];
            end else if (r_busy) begin
                if (!w_trial[VALUE_WIDTH]) begin
                    r_rem <= w_trial[VALUE_WIDTH-1:0];
                    r_quo <= {r_quo[VALUE_WIDTH-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[VALUE_WIDTH-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_q    = r_neg ? t_value'(-r_quo) : r_quo;
endmodule

// ===== rtl/iee_datapath.sv =====
// Datapath: character decode, number builder, both stacks, ALU and error register.
module iee_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  iee_pkg::t_cmd    i_cmd,
    input  logic [7:0]       i_character,
    input  logic             i_last_char,
    output iee_pkg::t_sts    o_sts,
    output iee_pkg::t_value  o_result
);
    import iee_pkg::*;

    t_value     r_opd_mem [STACK_DEPTH];
    logic [2:0] r_opr_mem [STACK_DEPTH];
    t_count     r_opd_cnt;
    t_count     r_opr_cnt;
    t_value     r_acc;
    logic       r_pend;
    t_status    r_err;
    logic [7:0] r_char;
    logic       r_last;
    t_opc       r_top;
    t_value     r_b;
    t_value     r_rd;
    logic       r_div_pend;

    t_cclass    w_cc;
    t_opc       w_op;
    t_value     w_alu;
    logic       w_div_start;
    logic       w_div_busy;
    logic       w_div_done;
    t_value     w_q;
    logic       w_push_val;
    t_value     w_push_data;

    always_comb begin
        w_op = OPC_ADD;
        w_cc = CC_OTHER;
        if (r_char >= 8'h30 && r_char <= 8'h39) w_cc = CC_DIGIT;
        else if (r_char == 8'h28) w_cc = CC_LPAREN;
        else if (r_char == 8'h29) w_cc = CC_RPAREN;
        else if (r_char == 8'h2B) begin w_cc = CC_OPER; w_op = OPC_ADD; end
        else if (r_char == 8'h2D) begin w_cc = CC_OPER; w_op = OPC_SUB; end
        else if (r_char == 8'h2A) begin w_cc = CC_OPER; w_op = OPC_MUL; end
        else if (r_char == 8'h2F) begin w_cc = CC_OPER; w_op = OPC_DIV; end
    end

    // Left operand sits in r_rd during exec.
    always_comb begin
        unique case (r_top)
            OPC_ADD: w_alu = r_rd + r_b;
            OPC_SUB: w_alu = r_rd - r_b;
            OPC_MUL: w_alu = t_value'(r_rd * r_b);
            default: w_alu = '0;
        endcase
    end

    assign w_div_start = i_cmd.exec && r_top == OPC_DIV && r_b != '0 && r_err == ST_OK;

    iee_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_a     (r_rd),
        .i_b     (r_b),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_q     (w_q)
    );

    // One operand push source: flushed number, ALU result or quotient.
    always_comb begin
        w_push_val  = 1'b0;
        w_push_data = w_alu;
        if (i_cmd.flush && r_pend) begin
            w_push_val  = 1'b1;
            w_push_data = r_acc;
        end else if (i_cmd.exec && r_top != OPC_DIV) begin
            w_push_val = 1'b1;
        end else if (w_div_done && r_div_pend) begin
            w_push_val  = 1'b1;
            w_push_data = w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_val && r_err == ST_OK && r_opd_cnt < t_count'(STACK_DEPTH))
            r_opd_mem[r_opd_cnt[SP_W-1:0]] <= w_push_data;
        if (i_cmd.push_cur_op && r_err == ST_OK && r_opr_cnt < t_count'(STACK_DEPTH))
            r_opr_mem[r_opr_cnt[SP_W-1:0]] <= (w_cc == CC_LPAREN) ? OPC_LPAREN : w_op;
        if (i_cmd.read_top_op)
            r_top <= t_opc'(r_opr_mem[r_opr_cnt[SP_W-1:0] - 1'b1]);
        if (i_cmd.pop_b || i_cmd.pop_a || i_cmd.read_result)
            r_rd <= r_opd_mem[i_cmd.read_result ? '0 : r_opd_cnt[SP_W-1:0] - 1'b1];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_char) begin
            r_char <= i_character;
            r_last <= i_last_char;
        end
        if (i_cmd.pop_a) r_b <= r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_opd_cnt  <= '0;
            r_opr_cnt  <= '0;
            r_acc      <= '0;
            r_pend     <= 1'b0;
            r_err      <= ST_OK;
            r_div_pend <= 1'b0;
        end else begin
            if (i_cmd.acc_digit) begin
                r_acc  <= t_value'(r_acc * VALUE_WIDTH'(10) + t_value'(r_char - 8'h30));
                r_pend <= 1'b1;
            end
            if (i_cmd.flush) begin
                r_acc  <= '0;
                r_pend <= 1'b0;
            end
            if (i_cmd.pop_op && r_opr_cnt != '0) r_opr_cnt <= r_opr_cnt - 1'b1;
            if (i_cmd.pop_b || i_cmd.pop_a) r_opd_cnt <= r_opd_cnt - 1'b1;
            if (i_cmd.push_cur_op && r_err == ST_OK) begin
                if (r_opr_cnt < t_count'(STACK_DEPTH)) r_opr_cnt <= r_opr_cnt + 1'b1;
                else r_err <= ST_OVERFLOW;
            end
            if (w_push_val && r_err == ST_OK) begin
                if (r_opd_cnt < t_count'(STACK_DEPTH)) r_opd_cnt <= r_opd_cnt + 1'b1;
                else r_err <= ST_OVERFLOW;
            end
            if (i_cmd.exec && r_top == OPC_DIV) begin
                if (r_b == '0) r_err <= ST_DIVZERO;
                else r_div_pend <= 1'b1;
            end
            if (w_div_done) r_div_pend <= 1'b0;
            if (i_cmd.set_err && r_err == ST_OK) r_err <= i_cmd.err_code;
        end
    end

    assign o_sts.cclass   = w_cc;
    assign o_sts.cur_op   = w_op;
    assign o_sts.last     = r_last;
    assign o_sts.err      = r_err;
    assign o_sts.opd_cnt  = r_opd_cnt;
    assign o_sts.opr_cnt  = r_opr_cnt;
    assign o_sts.top_op   = r_top;
    assign o_sts.div_busy = w_div_busy || w_div_start;
    assign o_sts.div_done = w_div_done;
    // Bottom operand, held in r_rd from the result read until the stacks clear.
    assign o_result       = (r_err == ST_OK) ? r_rd : '0;
endmodule

// ===== rtl/iee_controller.sv =====
// Controller: sequences character handling, reductions and the final result.
module iee_controller (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  iee_pkg::t_sts   i_sts,
    output iee_pkg::t_cmd   o_cmd
);
    import iee_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_final;
    logic   n_final;
    logic   w_ok;
    logic   w_more;

    assign w_ok = (i_sts.err == ST_OK);

    // Whether the top operator should be reduced before going on.
    always_comb begin
        if (r_final) w_more = 1'b1;
        else if (i_sts.cclass == CC_RPAREN) w_more = (i_sts.top_op != OPC_LPAREN);
        else w_more = (prec(i_sts.top_op) >= prec(i_sts.cur_op));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
        end
    end

    always_comb begin
        n_state = r_state;
        n_final = r_final;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                n_state = S_DISPATCH;
                n_final = 1'b0;
            end
            S_DISPATCH: begin
                if (!w_ok || i_sts.cclass == CC_DIGIT || i_sts.cclass == CC_OTHER
                        && !i_sts.last)
                    n_state = i_sts.last ? S_FLUSH : S_IDLE;
                else if (i_sts.cclass == CC_OTHER)
                    n_state = S_FLUSH;
                else if (i_sts.cclass == CC_LPAREN)
                    n_state = S_PUSHOP;
                else
                    n_state = S_TOPREAD;
                if (w_ok && i_sts.cclass == CC_DIGIT && i_sts.last) n_state = S_FLUSH;
                if (!w_ok) n_state = i_sts.last ? S_FINAL : S_IDLE;
            end
            S_FLUSH: begin
                n_final = 1'b1;
                n_state = S_TOPREAD;
            end
            S_TOPREAD: begin
                if (!w_ok || i_sts.opr_cnt == '0) n_state = S_PUSHOP;
                else n_state = S_TOPCHK;
            end
            S_TOPCHK: begin
                // A ')' that meets its '(' is done here.
                if (!w_more && i_sts.cclass == CC_RPAREN)
                    n_state = i_sts.last ? S_FLUSH : S_IDLE;
                else if (!w_more) n_state = S_PUSHOP;
                else if (i_sts.top_op == OPC_LPAREN || i_sts.opd_cnt < t_count'(2))
                    n_state = S_PUSHOP;
                else n_state = S_POP_B;
            end
            S_POP_B:   n_state = S_POP_A;
            S_POP_A:   n_state = S_EXEC;
            S_EXEC:    n_state = (i_sts.top_op == OPC_DIV) ? S_DIVWAIT : S_TOPREAD;
            S_DIVWAIT: if (!i_sts.div_busy) n_state = S_TOPREAD;
            S_PUSHOP:  n_state = r_final ? S_FINAL : (i_sts.last ? S_FLUSH : S_IDLE);
            S_FINAL:   n_state = S_RES_READ;
            S_RES_READ: n_state = S_OUT;
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.err_code = ST_OK;
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_char = i_in_valid;
            end
            S_DISPATCH: begin
                if (w_ok && i_sts.cclass == CC_DIGIT) o_cmd.acc_digit = 1'b1;
                else if (w_ok) o_cmd.flush = 1'b1;
            end
            S_FLUSH: o_cmd.flush = w_ok;
            S_TOPREAD: o_cmd.read_top_op = 1'b1;
            S_TOPCHK: begin
                if (w_more) begin
                    o_cmd.pop_op = 1'b1;
                    if (i_sts.top_op == OPC_LPAREN && (r_final || i_sts.cclass != CC_RPAREN)
                            || i_sts.opd_cnt < t_count'(2)) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = ST_MALFORMED;
                    end else begin
                        o_cmd.pop_b = 1'b1;
                    end
                end else if (i_sts.cclass == CC_RPAREN) begin
                    // Matching '(' consumed; no push follows.
                    o_cmd.pop_op = 1'b1;
                end
            end
            S_POP_A: o_cmd.pop_a = 1'b1;
            S_EXEC:  o_cmd.exec  = 1'b1;
            S_PUSHOP: begin
                if (w_ok && !r_final) begin
                    if (i_sts.cclass == CC_RPAREN) begin
                        if (i_sts.opr_cnt == '0) begin
                            o_cmd.set_err  = 1'b1;
                            o_cmd.err_code = ST_MALFORMED;
                        end
                    end else begin
                        o_cmd.push_cur_op = 1'b1;
                    end
                end
            end
            S_FINAL: begin
                if (w_ok && (i_sts.opr_cnt != '0 || i_sts.opd_cnt != t_count'(1))) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_MALFORMED;
                end
            end
            S_RES_READ: o_cmd.read_result = 1'b1;
            S_OUT: begin
                o_out_valid = 1'b1;
                // Stacks clear as the result word is taken.
                o_cmd.clear = i_out_ready;
            end
            default: ;
        endcase
    end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for the infix expression evaluator: directed and random expressions checked.
module testbench;
    import iee_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_character;
    logic        i_last_char;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_value;
    logic [1:0]  o_status;

    infix_expression_evaluator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_character(i_character), .i_last_char(i_last_char),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_value(o_value), .o_status(o_status)
    );

    localparam int CYCLE_LIMIT = 3000000;

    // Expected result words, oldest first.
    typedef struct packed {
        logic [31:0] value;
        t_status     status;
    } t_result;
    t_result result_q[$];

    // Predictor state: mirrors the evaluator stacks and counters.
    t_value  calc_vals[STACK_DEPTH];
    t_opc    calc_ops[STACK_DEPTH];
    int      calc_nvals;
    int      calc_nops;
    t_value  calc_acc;
    logic    calc_pending;
    t_status calc_err;

    int  fail_count;
    longint cycle_count;
    logic drain_done;
    int  ready_wait;

    // Expression text buffer; the send helpers take their text as an argument instead.
    string expr_text;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Watchdog: ends the run if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void calc_clear();
        calc_nvals   = 0;
        calc_nops    = 0;
        calc_acc     = '0;
        calc_pending = 1'b0;
        calc_err     = ST_OK;
    endfunction

    function automatic void calc_push_val(t_value v);
        if (calc_err != ST_OK) return;
        if (calc_nvals >= STACK_DEPTH) begin
            calc_err = ST_OVERFLOW;
            return;
        end
        calc_vals[calc_nvals] = v;
        calc_nvals++;
    endfunction

    function automatic void calc_push_op(t_opc op);
        if (calc_err != ST_OK) return;
        if (calc_nops >= STACK_DEPTH) begin
            calc_err = ST_OVERFLOW;
            return;
        end
        calc_ops[calc_nops] = op;
        calc_nops++;
    endfunction

    function automatic int op_rank(t_opc op);
        if (op == OPC_MUL || op == OPC_DIV) return 2;
        if (op == OPC_ADD || op == OPC_SUB) return 1;
        return 0;
    endfunction

    function automatic void calc_reduce();
        t_opc op;
        logic signed [31:0] a, b, r;
        logic [31:0] ma, mb, q;
        if (calc_err != ST_OK) return;
        if (calc_nops == 0) begin
            calc_err = ST_MALFORMED;
            return;
        end
        calc_nops--;
        op = calc_ops[calc_nops];
        if (op == OPC_LPAREN || calc_nvals < 2) begin
            calc_err = ST_MALFORMED;
            return;
        end
        b = calc_vals[calc_nvals-1];
        a = calc_vals[calc_nvals-2];
        calc_nvals -= 2;
        case (op)
            OPC_ADD: r = a + b;
            OPC_SUB: r = a - b;
            OPC_MUL: r = a * b;
            default: begin
                if (b == 0) begin
                    calc_err = ST_DIVZERO;
                    return;
                end
                // magnitudes as unsigned so the most negative value survives
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q  = ma / mb;
                r  = (a[31] != b[31]) ? -q : q;
            end
        endcase
        calc_push_val(r);
    endfunction

    function automatic void calc_flush();
        if (calc_pending) calc_push_val(calc_acc);
        calc_acc     = '0;
        calc_pending = 1'b0;
    endfunction

    // Advances the predictor by one character; queues a result on the last one.
    function automatic void calc_char(logic [7:0] c, logic last);
        t_opc op;
        logic is_op;
        t_result res;
        if (calc_err == ST_OK) begin
            if (c >= "0" && c <= "9") begin
                calc_acc     = calc_acc * 10 + (c - 8'h30);
                calc_pending = 1'b1;
            end else begin
                calc_flush();
                if (c == "(") begin
                    calc_push_op(OPC_LPAREN);
                end else if (c == ")") begin
                    while (calc_err == ST_OK && calc_nops > 0 &&
                           calc_ops[calc_nops-1] != OPC_LPAREN)
                        calc_reduce();
                    if (calc_err == ST_OK) begin
                        if (calc_nops == 0) calc_err = ST_MALFORMED;
                        else calc_nops--;
                    end
                end else begin
                    is_op = 1'b1;
                    op = OPC_ADD;
                    case (c)
                        "+": op = OPC_ADD;
                        "-": op = OPC_SUB;
                        "*": op = OPC_MUL;
                        "/": op = OPC_DIV;
                        default: is_op = 1'b0;
                    endcase
                    if (is_op) begin
                        while (calc_err == ST_OK && calc_nops > 0 &&
                               op_rank(calc_ops[calc_nops-1]) >= op_rank(op))
                            calc_reduce();
                        calc_push_op(op);
                    end
                end
            end
        end
        if (!last) return;
        if (calc_err == ST_OK) calc_flush();
        while (calc_err == ST_OK && calc_nops > 0) calc_reduce();
        if (calc_err == ST_OK && calc_nvals != 1) calc_err = ST_MALFORMED;
        res.value  = (calc_err == ST_OK) ? calc_vals[0] : '0;
        res.status = calc_err;
        result_q.push_back(res);
        calc_clear();
    endfunction

    // Sends one character word with a random lead-in gap; valid stays up when there is none.
    task automatic send_char(logic [7:0] c, logic last);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_character <= c;
        i_last_char <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        calc_char(c, last);
    endtask

    // Sends a whole expression; the final character carries the last flag.
    task automatic send_expr(string s);
        int n;
        n = s.len();
        for (int k = 0; k < n; k++) send_char(s[k], k == n - 1);
    endtask

    // Result word checker; draws a wait for every result word.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            ready_wait = $urandom_range(0, 18);
        end else begin
            if (o_valid && i_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result value %0d status %0d",
                             $time, $signed(o_value), o_status);
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (o_value !== want.value) begin
                        $display("%0t: value expected %0d actual %0d", $time,
                                 $signed(want.value), $signed(o_value));
                        fail_count++;
                    end
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, o_status);
                        fail_count++;
                    end
                end
                ready_wait = $urandom_range(0, 18);
            end else if (o_valid && ready_wait > 0) begin
                ready_wait--;
            end
            i_ready <= (ready_wait == 0);
        end
    end

    function automatic string rand_number();
        string s;
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 3);
        s = "";
        for (int k = 0; k < n; k++) s = {s, $sformatf("%c", 8'h30 + $urandom_range(0, 9))};
        return s;
    endfunction

    // Builds a well-formed expression with random numbers, operators and groups.
    function automatic string rand_term(int depth);
        string s;
        int n;
        byte ops[4];
        ops = '{"+", "-", "*", "/"};
        n = $urandom_range(0, 4);
        s = "";
        for (int k = 0; k <= n; k++) begin
            if (k > 0) s = {s, string'(ops[$urandom_range(0, 3)])};
            if ($urandom_range(0, 7) == 0) s = {s, " "};
            if (depth > 0 && $urandom_range(0, 4) == 0)
                s = {s, "(", rand_term(depth - 1), ")"};
            else
                s = {s, rand_number()};
        end
        return s;
    endfunction

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        string deep;
        send_expr("0");
        send_expr("4294967295");
        send_expr("2147483647+1");
        send_expr("1+2*3-4/2");
        send_expr("(1+2)*3");
        send_expr("10-3-2");
        send_expr("100/7/2");
        send_expr("0-7/2");
        send_expr("5/0");
        send_expr("2147483648/4294967295");
        send_expr("99999999999");
        send_expr("1 2");
        send_expr("(1+2");
        send_expr("1+2)");
        send_expr("+");
        send_expr(" ");
        send_expr("3)5+4");
        send_expr({"1+a#2", $sformatf("%c", 8'hff)});
        deep = "";
        for (int k = 0; k < 33; k++) deep = {deep, "("};
        send_expr({deep, "1"});
        deep = "";
        for (int k = 0; k < 33; k++) deep = {deep, "1+"};
        send_expr({deep, "1"});
        deep = "";
        for (int k = 0; k < 33; k++) deep = {deep, "1*("};
        send_expr({deep, "1"});
    endtask

    task automatic test_random_exprs();
        int sent;
        string s;
        sent = 0;
        while (sent < 1530) begin
            if ($urandom_range(0, 9) < 8) begin
                s = rand_term(3);
            end else begin
                // noise: any nonzero byte, covering every bit of the character field
                s = "";
                for (int k = $urandom_range(0, 8); k >= 0; k--)
                    s = {s, $sformatf("%c", $urandom_range(1, 255))};
            end
            send_expr(s);
            sent += s.len();
            if (sent % 500 < s.len()) wait_idle();
        end
        send_char(8'h00, 1'b1);
        send_char(8'hff, 1'b1);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_character <= '0;
        i_last_char <= 1'b0;
        fail_count  = 0;
        cycle_count = 0;
        calc_clear();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_idle();
        test_random_exprs();
        wait_idle();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
